[hw/rtl/huf_pkg.sv]
// huf_pkg: shared types, constants and engine states for the huffman decoder
// depends on nothing; used by every other file of the block but huf_if
`default_nettype none
package huf_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned MAX_CODE_BITS_DEF = 32;
  localparam int unsigned TOP_BIT           = 7;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // input command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_BYTE  = 2'd2;

  // word class decided by the front end
  typedef enum logic [1:0] {
    K_NONE,
    K_CLEAR,
    K_LOAD,
    K_BYTE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  entry_symbol;
    logic [31:0] entry_code;
    logic [5:0]  entry_length;
  } item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       status;
    logic       last;
    logic       finished;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LSCAN,
    S_BIT,
    S_DSCAN,
    S_PUT,
    S_FLUSH
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/huf_if.sv]
// huf_in_if and huf_out_if: valid/ready channels of the huffman decoder
// depends on nothing
`default_nettype none
interface huf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic [7:0]  entry_symbol;
  logic [31:0] entry_code;
  logic [5:0]  entry_length;
  modport source (output valid, command, data_byte, entry_symbol, entry_code,
                  entry_length, input ready);
  modport sink (input valid, command, data_byte, entry_symbol, entry_code,
                entry_length, output ready);
endinterface

interface huf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       status;
  logic       last;
  logic       finished;
  modport source (output valid, symbol, status, last, finished, input ready);
  modport sink (input valid, symbol, status, last, finished, output ready);
endinterface
`default_nettype wire

[hw/rtl/huf_front.sv]
// huf_front: accepts input words, classifies them and queues them
// depends on huf_pkg and huf_in_if
`default_nettype none
module huf_front #(
  parameter int unsigned MAX_CODE_BITS = huf_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  huf_in_if.sink             in_ch,
  output huf_pkg::item_t     q_item,
  output logic               q_valid,
  input  wire logic          pop
);

  localparam int unsigned PW = $clog2(huf_pkg::QUEUE_DEPTH);

  huf_pkg::item_t  slots [huf_pkg::QUEUE_DEPTH];
  huf_pkg::item_t  cls;
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;
  logic [31:0]     code_mask;

  // classify and mask the code to its length
  always_comb begin
    code_mask = (in_ch.entry_length >= 6'd32) ? '1 :
                ((32'd1 << in_ch.entry_length) - 32'd1);
    cls.data_byte    = in_ch.data_byte;
    cls.entry_symbol = in_ch.entry_symbol;
    cls.entry_code   = in_ch.entry_code & code_mask;
    cls.entry_length = in_ch.entry_length;
    unique case (in_ch.command)
      huf_pkg::CMD_CLEAR: cls.kind = huf_pkg::K_CLEAR;
      huf_pkg::CMD_LOAD: begin
        if (in_ch.entry_length != 6'd0 && 32'(in_ch.entry_length) <= MAX_CODE_BITS)
          cls.kind = huf_pkg::K_LOAD;
        else
          cls.kind = huf_pkg::K_NONE;
      end
      huf_pkg::CMD_BYTE: cls.kind = huf_pkg::K_BYTE;
      default: cls.kind = huf_pkg::K_NONE;
    endcase
  end

  assign in_ch.ready = (count < (PW+1)'(huf_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != '0);
  assign q_item      = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/huf_engine.sv]
// huf_engine: code table, bit collection and table scan, result hold-back
// depends on huf_pkg
`default_nettype none
module huf_engine #(
  parameter int unsigned TABLE_ENTRIES = huf_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_CODE_BITS = huf_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  input  wire huf_pkg::item_t q_item,
  input  wire logic           q_valid,
  output logic                pop,
  input  wire logic           slot_free,
  output logic                res_push,
  output huf_pkg::res_t       res
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned LW = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned CW = MAX_CODE_BITS;

  // table memory
  logic [CW-1:0] mem_code [TABLE_ENTRIES];
  logic [LW-1:0] mem_len  [TABLE_ENTRIES];
  logic [7:0]    mem_sym  [TABLE_ENTRIES];

  huf_pkg::state_t state, state_next;
  logic [IW:0]     fill;
  logic [IW:0]     idx;
  logic            rd_vld;
  logic [IW-1:0]   rd_idx;
  logic [CW-1:0]   rd_code;
  logic [LW-1:0]   rd_len;
  logic [7:0]      rd_sym;
  logic [CW-1:0]   key_code;
  logic [LW-1:0]   key_len;
  logic [7:0]      ld_sym;
  logic [CW-1:0]   pend_bits;
  logic [LW-1:0]   pend_cnt;
  logic [31:0]     emitted;
  logic            done;
  logic [31:0]     olen;
  logic [7:0]      byte_reg;
  logic [2:0]      bitpos;
  huf_pkg::res_t   hold;
  logic            hold_vld;
  huf_pkg::res_t   nres;

  logic            scan_hit, scan_end, overflow, fin_now, put_go;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [CW-1:0]   bits_shift;

  // scan compare against the registered read word
  assign scan_hit  = rd_vld && rd_len == key_len && rd_code == key_code;
  assign scan_end  = !rd_vld && idx >= fill;
  assign overflow  = (32'(pend_cnt) >= MAX_CODE_BITS);
  assign fin_now   = !nres.status && olen != 32'd0 && emitted >= olen;
  assign put_go    = !hold_vld || slot_free;
  assign bits_shift = {pend_bits[CW-2:0], byte_reg[bitpos]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      huf_pkg::S_IDLE: begin
        if (q_valid) begin
          unique case (q_item.kind)
            huf_pkg::K_LOAD: state_next = huf_pkg::S_LSCAN;
            huf_pkg::K_BYTE: state_next = done ? huf_pkg::S_IDLE : huf_pkg::S_BIT;
            default:         state_next = huf_pkg::S_IDLE;
          endcase
        end
      end
      huf_pkg::S_LSCAN: if (scan_hit || scan_end) state_next = huf_pkg::S_IDLE;
      huf_pkg::S_BIT:   state_next = huf_pkg::S_DSCAN;
      huf_pkg::S_DSCAN: begin
        if (scan_hit || (scan_end && overflow))
          state_next = huf_pkg::S_PUT;
        else if (scan_end)
          state_next = (bitpos != 3'd0) ? huf_pkg::S_BIT :
                       (hold_vld ? huf_pkg::S_FLUSH : huf_pkg::S_IDLE);
      end
      huf_pkg::S_PUT: begin
        if (put_go)
          state_next = (fin_now || bitpos == 3'd0) ? huf_pkg::S_FLUSH : huf_pkg::S_BIT;
      end
      huf_pkg::S_FLUSH: if (slot_free) state_next = huf_pkg::S_IDLE;
      default: state_next = huf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop      = (state == huf_pkg::S_IDLE) && q_valid;
    res_push = ((state == huf_pkg::S_PUT) && hold_vld && slot_free) ||
               ((state == huf_pkg::S_FLUSH) && slot_free);
    res      = hold;
    res.last = (state == huf_pkg::S_FLUSH);
    mem_we   = 1'b0;
    mem_wa   = rd_idx;
    if (state == huf_pkg::S_LSCAN) begin
      if (scan_hit) begin
        mem_we = 1'b1;
      end else if (scan_end && fill < (IW+1)'(TABLE_ENTRIES)) begin
        mem_we = 1'b1;
        mem_wa = fill[IW-1:0];
      end
    end
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_code[mem_wa] <= key_code;
      mem_len[mem_wa]  <= key_len;
      mem_sym[mem_wa]  <= ld_sym;
    end
    rd_code <= mem_code[idx[IW-1:0]];
    rd_len  <= mem_len[idx[IW-1:0]];
    rd_sym  <= mem_sym[idx[IW-1:0]];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= huf_pkg::S_IDLE;
      fill     <= '0;
      idx      <= '0;
      rd_vld   <= 1'b0;
      pend_bits <= '0;
      pend_cnt <= '0;
      emitted  <= '0;
      done     <= 1'b0;
      olen     <= '0;
      hold_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) olen <= cfg_wdata;

      // scan address walk
      if (state == huf_pkg::S_LSCAN || state == huf_pkg::S_DSCAN) begin
        rd_vld <= (idx < fill);
        rd_idx <= idx[IW-1:0];
        if (idx < fill) idx <= idx + 1'b1;
      end else begin
        idx    <= '0;
        rd_vld <= 1'b0;
      end

      unique case (state)
        huf_pkg::S_IDLE: begin
          if (q_valid) begin
            unique case (q_item.kind)
              huf_pkg::K_CLEAR: begin
                fill      <= '0;
                pend_bits <= '0;
                pend_cnt  <= '0;
                emitted   <= '0;
                done      <= 1'b0;
              end
              huf_pkg::K_LOAD: begin
                key_code <= CW'(q_item.entry_code);
                key_len  <= LW'(q_item.entry_length);
                ld_sym   <= q_item.entry_symbol;
              end
              huf_pkg::K_BYTE: begin
                byte_reg <= q_item.data_byte;
                bitpos   <= 3'(huf_pkg::TOP_BIT);
              end
              default: ;
            endcase
          end
        end
        huf_pkg::S_LSCAN: begin
          if (!scan_hit && scan_end && fill < (IW+1)'(TABLE_ENTRIES))
            fill <= fill + 1'b1;
        end
        huf_pkg::S_BIT: begin
          pend_bits <= bits_shift;
          pend_cnt  <= pend_cnt + 1'b1;
          key_code  <= bits_shift;
          key_len   <= pend_cnt + 1'b1;
        end
        huf_pkg::S_DSCAN: begin
          if (scan_hit) begin
            nres      <= '{symbol: rd_sym, status: 1'b0, last: 1'b0, finished: 1'b0};
            pend_bits <= '0;
            pend_cnt  <= '0;
            emitted   <= emitted + 32'd1;
          end else if (scan_end && overflow) begin
            nres      <= '{symbol: 8'd0, status: 1'b1, last: 1'b0, finished: 1'b0};
            pend_bits <= '0;
            pend_cnt  <= '0;
          end else if (scan_end && bitpos != 3'd0) begin
            bitpos <= bitpos - 3'd1;
          end
        end
        huf_pkg::S_PUT: begin
          if (put_go) begin
            hold     <= '{symbol: nres.symbol, status: nres.status, last: 1'b0,
                          finished: fin_now};
            hold_vld <= 1'b1;
            if (fin_now) done <= 1'b1;
            if (bitpos != 3'd0) bitpos <= bitpos - 3'd1;
          end
        end
        huf_pkg::S_FLUSH: if (slot_free) hold_vld <= 1'b0;
        default: ;
      endcase
    end
  end

  // a held result never survives into idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == huf_pkg::S_IDLE |-> !hold_vld) else $error("held result left in idle");

  // collected bits never pass the longest code
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pend_cnt) <= MAX_CODE_BITS) else $error("pending count overrun");

  // fill count bounded by the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (IW+1)'(TABLE_ENTRIES)) else $error("table fill overrun");

  // once finished no new byte starts decoding
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    (state == huf_pkg::S_IDLE && done) |=> state != huf_pkg::S_BIT)
    else $error("byte decoded after finish");

endmodule
`default_nettype wire

[hw/rtl/huf_outreg.sv]
// huf_outreg: output register that holds one result word for the sink
// depends on huf_pkg and huf_out_if
`default_nettype none
module huf_outreg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire huf_pkg::res_t res,
  output logic               slot_free,
  huf_out_if.source          out_ch
);

  logic          valid;
  huf_pkg::res_t data;

  assign slot_free       = !valid || out_ch.ready;
  assign out_ch.valid    = valid;
  assign out_ch.symbol   = data.symbol;
  assign out_ch.status   = data.status;
  assign out_ch.last     = data.last;
  assign out_ch.finished = data.finished;

  // load on push, drain on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) data <= res;
  end

endmodule
`default_nettype wire

[hw/rtl/huffman_bitwise_decoder.sv]
// huffman_bitwise_decoder: top level, front queue, decode engine, output register
// depends on huf_pkg, huf_if, huf_front, huf_engine, huf_outreg
//
// channel   dir  word
// in_ch     in   command, data_byte, entry_symbol, entry_code, entry_length
// out_ch    out  symbol, status, last, finished
// cfg       in   cfg_we, cfg_wdata (output_length)
//
// each code bit costs a scan of the filled table entries through one read port,
// and each result adds a put step
// a load scans the filled entries once; a clear is taken in the idle state
// the two-word input queue keeps accepting while the engine works, until it is full
// reset is synchronous; the table is empty after reset or a clear command
// results wait in the output register while the sink stalls
`default_nettype none
module huffman_bitwise_decoder #(
  parameter int unsigned TABLE_ENTRIES = huf_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_CODE_BITS = huf_pkg::MAX_CODE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  huf_in_if.sink           in_ch,
  huf_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  huf_pkg::item_t q_item;
  huf_pkg::res_t  res;
  logic           q_valid, pop, slot_free, res_push;

  huf_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
    .clk, .rst, .in_ch, .q_item, .q_valid, .pop
  );

  huf_engine #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_engine (
    .clk, .rst, .cfg_we, .cfg_wdata, .q_item, .q_valid, .pop,
    .slot_free, .res_push, .res
  );

  huf_outreg u_out (
    .clk, .rst, .push(res_push), .res, .slot_free, .out_ch
  );

endmodule
`default_nettype wire
